// ===== hdl/angle_sensor_frame_receiver_core_defines.svh =====
// Assertion macros for the angle sensor frame receiver.
`ifndef ANGLE_SENSOR_FRAME_RECEIVER_CORE_DEFINES_SVH
`define ANGLE_SENSOR_FRAME_RECEIVER_CORE_DEFINES_SVH

// Checked only while out of reset.
`define ASFR_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASFR_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/asfr_pkg.sv =====
`default_nettype none

package asfr_pkg;

    // Frame byte positions
    localparam logic [2:0] POS_CMD  = 3'd0;
    localparam logic [2:0] POS_ADDR = 3'd1;
    localparam logic [2:0] POS_HI   = 3'd2;
    localparam logic [2:0] POS_MID  = 3'd3;
    localparam logic [2:0] POS_LO   = 3'd4;
    localparam logic [2:0] POS_CRC  = 3'd5;
    localparam logic [2:0] POS_IDLE = 3'd6;

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_INIT = 8'h00;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
        logic       diag_low;
    } item_t;

    typedef struct packed {
        logic [20:0] angle_raw;
        logic [2:0]  magnet_status;
        logic        diag_flag;
        logic        crc_good;
    } result_t;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/asfr_frame_dec.sv =====
`default_nettype none

module asfr_frame_dec
    import asfr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    step,
    input  wire item_t   item,
    input  wire logic    diag_enable,
    output logic         emit,
    output result_t      result
);

    logic [2:0]  pos_reg,   pos_next;
    logic [7:0]  crc_reg,   crc_next;
    logic [15:0] upper_reg, upper_next;
    logic [7:0]  lower_reg, lower_next;
    logic [2:0]  pos;
    logic        good;

    assign pos  = item.frame_start ? POS_CMD : pos_reg;
    assign emit = (pos == POS_CRC);
    assign good = (crc_reg == item.rx_byte);

    always_comb
    begin
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        upper_next = upper_reg;
        lower_next = lower_reg;
        if (step)
        begin
            unique case (pos)
                POS_CMD, POS_ADDR:
                begin
                    crc_next = CRC_INIT;
                    pos_next = pos + 3'd1;
                end
                POS_HI:
                begin
                    crc_next   = crc8_byte(crc_reg, item.rx_byte);
                    upper_next = {item.rx_byte, 8'h00};
                    pos_next   = POS_MID;
                end
                POS_MID:
                begin
                    crc_next   = crc8_byte(crc_reg, item.rx_byte);
                    upper_next = {upper_reg[15:8], item.rx_byte};
                    pos_next   = POS_LO;
                end
                POS_LO:
                begin
                    crc_next   = crc8_byte(crc_reg, item.rx_byte);
                    lower_next = item.rx_byte;
                    pos_next   = POS_CRC;
                end
                default:
                begin
                    pos_next = POS_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        result.angle_raw     = good ? {upper_reg, lower_reg[7:3]} : 21'd0;
        result.magnet_status = good ? lower_reg[2:0] : 3'd0;
        result.diag_flag     = diag_enable & item.diag_low;
        result.crc_good      = good;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_CMD;
            crc_reg   <= CRC_INIT;
            upper_reg <= 16'd0;
            lower_reg <= 8'd0;
        end
        else
        begin
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            upper_reg <= upper_next;
            lower_reg <= lower_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/angle_sensor_frame_receiver_core.sv =====
// Angle sensor read-frame receiver. Takes the six bytes of a sensor read
// frame one transfer at a time; frame_start marks byte one and restarts the
// count at any point. Bytes one and two are dropped, bytes three to five are
// run through CRC-8 (poly 0x07, init 0) and packed, and byte six is checked
// against the CRC. The sixth byte yields one output transfer: 21-bit angle and
// 3-bit magnet status (both zero on a CRC mismatch), crc_good, and diag_flag
// (diag_enable AND diag_low of byte six). All other bytes give no output.
// Throughput is one byte per cycle. The byte lands in the input register at
// its input transfer; from there its result is written to the result
// register, which drives out_valid. The input only stalls when a
// result-producing byte meets a full, stalled output register.
// diag_enable is written through cfg_we/cfg_wdata and should change only
// while the block is idle.
`default_nettype none
`include "angle_sensor_frame_receiver_core_defines.svh"

module angle_sensor_frame_receiver_core
    import asfr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    // byte input
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        frame_start,
    input  wire logic        diag_low,
    // result output
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [20:0]      angle_raw,
    output logic [2:0]       magnet_status,
    output logic             diag_flag,
    output logic             crc_good
);

    logic    diag_enable_reg;

    // input register stage
    logic    s1_valid_reg, s1_valid_next;
    item_t   s1_item_reg;
    logic    s1_advance;
    logic    in_xfer;

    // result register stage
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;

    logic    emit;
    result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diag_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            diag_enable_reg <= cfg_wdata;
        end
    end

    // Frame state only moves when the staged byte leaves stage one.
    asfr_frame_dec u_dec (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (s1_advance),
        .item        (s1_item_reg),
        .diag_enable (diag_enable_reg),
        .emit        (emit),
        .result      (result)
    );

    // A byte that produces nothing can always leave; the CRC byte needs the
    // result register free or draining this cycle.
    assign s1_advance = s1_valid_reg & (~emit | ~out_valid_reg | out_ready);
    assign in_ready   = ~s1_valid_reg | s1_advance;
    assign in_xfer    = in_valid & in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_advance & emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_item_reg <= '{rx_byte: rx_byte, frame_start: frame_start,
                             diag_low: diag_low};
        end
        if (s1_advance & emit)
        begin
            out_res_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign angle_raw     = out_res_reg.angle_raw;
    assign magnet_status = out_res_reg.magnet_status;
    assign diag_flag     = out_res_reg.diag_flag;
    assign crc_good      = out_res_reg.crc_good;

    // Failed CRC must blank the angle and status.
    `ASFR_ASSERT(a_crc_fail_blanks, out_valid && !crc_good |-> angle_raw == 21'd0 && magnet_status == 3'd0, "angle/status not zero on CRC failure")
    // Input only backs up behind a held byte and a stalled result.
    `ASFR_ASSERT(a_stall_cause, !in_ready |-> s1_valid_reg && out_valid_reg && !out_ready, "input stalled without a blocked result")
    // Diagnostic flag needs the enable.
    `ASFR_ASSERT(a_diag_gated, out_valid |-> !diag_flag || diag_enable_reg, "diag_flag set while diagnostics disabled")
    // A reset edge leaves nothing presented.
    `ASFR_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid && !s1_valid_reg, "valid set after a reset edge")

endmodule

`default_nettype wire

// ===== verif/angle_sensor_frame_receiver_core_tb.sv =====
module angle_sensor_frame_receiver_core_tb;
    import asfr_pkg::*;

    // Run sizing
    localparam int LIMIT_CYCLES     = 400000;
    localparam int ITEMS_PER_PHASE  = 185;
    localparam int RANDOM_PHASES    = 8;
    localparam int HOLD_CYCLES      = 300;
    localparam int SETTLE_CYCLES    = 8;

    // Directed table: a row is either one byte transfer or a diag_enable write.
    // For a byte row, 'typed' selects the hand-written result over the predictor.
    typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [7:0] rx;      // byte, or the register value on a config row
        logic       st;
        logic       dl;
        logic       typed;
        result_t    res;
    } dir_row_t;

    localparam int N_DIRECTED = 29;

    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        // no start flag after reset: counting begins at byte one; all-zero data
        // has CRC zero, so this is a good frame with everything else zero
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b1, 1'b1, '{21'd0, 3'd0, 1'b0, 1'b1}},
        // trailing byte with no start flag: dropped
        '{ROW_BYTE, 8'hA5, 1'b0, 1'b1, 1'b0, '0},
        // all-ones data, largest angle and status
        '{ROW_BYTE, 8'hFF, 1'b1, 1'b1, 1'b0, '0},
        '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_BYTE, 8'h0F, 1'b0, 1'b1, 1'b0, '0},
        // partial frame with one data byte in the CRC, then a restart; the
        // command/address bytes must clear the stale CRC, so zero data vs 01
        // is a CRC failure
        '{ROW_BYTE, 8'h3C, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_BYTE, 8'hC3, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_BYTE, 8'h81, 1'b0, 1'b1, 1'b0, '0},
        '{ROW_BYTE, 8'h7E, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_BYTE, 8'hE7, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_BYTE, 8'h01, 1'b0, 1'b0, 1'b1, '{21'd0, 3'd0, 1'b0, 1'b0}},
        // diag line enabled: flag follows diag_low of byte six
        '{ROW_CFG,  8'h01, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_BYTE, 8'h00, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b1, 1'b1, '{21'd0, 3'd0, 1'b1, 1'b1}}
    };

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #2 clk = ~clk;

    // DUT inputs, all known from time zero
    logic       cfg_we      = 1'b0;
    logic       cfg_wdata   = 1'b0;
    logic       in_valid    = 1'b0;
    logic [7:0] rx_byte     = 8'h00;
    logic       frame_start = 1'b0;
    logic       diag_low    = 1'b0;
    logic       out_ready   = 1'b0;

    // DUT outputs
    logic        in_ready;
    logic        out_valid;
    logic [20:0] angle_raw;
    logic [2:0]  magnet_status;
    logic        diag_flag;
    logic        crc_good;

    angle_sensor_frame_receiver_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .frame_start   (frame_start),
        .diag_low      (diag_low),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .angle_raw     (angle_raw),
        .magnet_status (magnet_status),
        .diag_flag     (diag_flag),
        .crc_good      (crc_good)
    );

    // Frame decoder state mirrored in the bench
    logic [2:0]  frame_pos    = POS_CMD;
    logic [7:0]  crc_acc      = CRC_INIT;
    logic [15:0] angle_hi_mid = '0;
    logic [7:0]  angle_lo     = '0;
    logic        diag_en_copy = 1'b0;

    result_t readout_q [$];     // angle readouts still owed by the DUT
    int      bytes_taken = 0;   // accepted bytes that the decoder did not drop
    int      fail_count  = 0;
    int      cycle_count = 0;

    // Idle control shared with the receiver process
    bit tx_idling = 1'b1;
    bit rx_idling = 1'b1;
    bit hold_req  = 1'b0;

    // CRC-8 poly 0x07, bit-serial form, MSB first
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[7] ^ data[k];
            c  = {c[6:0], 1'b0};
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    // Mostly no gap or a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Advance the mirrored decoder by one accepted byte
    task automatic decode_byte(input logic [7:0] b, input logic st, input logic dl,
                               output bit produced, output bit dropped, output result_t res);
        logic [2:0] p;
        logic       good;
        p        = st ? POS_CMD : frame_pos;
        produced = 1'b0;
        dropped  = 1'b0;
        res      = '0;
        case (p)
            POS_CMD, POS_ADDR:
            begin
                crc_acc   = CRC_INIT;
                frame_pos = p + 3'd1;
            end
            POS_HI:
            begin
                crc_acc            = crc8_update(crc_acc, b);
                angle_hi_mid[15:8] = b;
                frame_pos          = POS_MID;
            end
            POS_MID:
            begin
                crc_acc           = crc8_update(crc_acc, b);
                angle_hi_mid[7:0] = b;
                frame_pos         = POS_LO;
            end
            POS_LO:
            begin
                crc_acc   = crc8_update(crc_acc, b);
                angle_lo  = b;
                frame_pos = POS_CRC;
            end
            POS_CRC:
            begin
                good              = (crc_acc == b);
                res.angle_raw     = good ? {angle_hi_mid, angle_lo[7:3]} : 21'd0;
                res.magnet_status = good ? angle_lo[2:0] : 3'd0;
                res.diag_flag     = diag_en_copy & dl;
                res.crc_good      = good;
                produced          = 1'b1;
                frame_pos         = POS_IDLE;
            end
            default:
            begin
                dropped   = 1'b1;
                frame_pos = POS_IDLE;
            end
        endcase
    endtask

    // One input transfer. Called right after the previous one was accepted, so
    // the first falling edge here is the one that follows that transfer.
    task automatic send_byte(input logic [7:0] b, input logic st, input logic dl,
                             input logic typed, input result_t typed_res);
        int      gap;
        bit      produced;
        bit      dropped;
        result_t res;
        gap = tx_idling ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        rx_byte     <= b;
        frame_start <= st;
        diag_low    <= dl;
        while (1)
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        decode_byte(b, st, dl, produced, dropped, res);
        if (produced)
            readout_q.push_back(typed ? typed_res : res);
        if (!dropped)
            bytes_taken++;
    endtask

    task automatic send_plain(input logic [7:0] b, input logic st);
        send_byte(b, st, 1'($urandom_range(0, 1)), 1'b0, '0);
    endtask

    // Drop valid, wait for every owed readout, then let the pipeline settle
    // (bytes that give no result may still be in flight)
    task automatic drain(input int settle);
        @(negedge clk);
        in_valid <= 1'b0;
        while (readout_q.size() > 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_diag_enable(input logic v);
        drain(SETTLE_CYCLES);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we       <= 1'b0;
        diag_en_copy = v;
    endtask

    // One random burst: mostly complete frames, some cut short, some noise
    task automatic send_frame();
        int         kind;
        int         n;
        logic [7:0] d [3];
        logic [7:0] chk;
        kind = $urandom_range(0, 19);
        if (kind < 14)
        begin
            for (int k = 0; k < 3; k++)
            begin
                case ($urandom_range(0, 9))
                    0:       d[k] = 8'h00;
                    1:       d[k] = 8'hFF;
                    default: d[k] = 8'($urandom_range(0, 255));
                endcase
            end
            chk = crc8_update(crc8_update(crc8_update(CRC_INIT, d[0]), d[1]), d[2]);
            // about one frame in five carries a corrupted CRC byte
            if ($urandom_range(0, 4) == 0)
                chk = 8'($urandom_range(0, 255));
            send_plain(8'($urandom_range(0, 255)), 1'b1);
            send_plain(8'($urandom_range(0, 255)), 1'b0);
            for (int k = 0; k < 3; k++)
                send_plain(d[k], 1'b0);
            send_plain(chk, 1'b0);
        end
        else if (kind < 16)
        begin
            // truncated frame, the next start flag drops it
            send_plain(8'($urandom_range(0, 255)), 1'b1);
            n = $urandom_range(1, 4);
            repeat (n) send_plain(8'($urandom_range(0, 255)), 1'b0);
        end
        else if (kind < 18)
        begin
            // stray bytes with no start flag
            n = $urandom_range(1, 4);
            repeat (n) send_plain(8'($urandom_range(0, 255)), 1'b0);
        end
        else
        begin
            // start flags at random
            n = $urandom_range(1, 8);
            repeat (n) send_plain(8'($urandom_range(0, 255)), 1'($urandom_range(0, 5) == 0));
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (rx_idling && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Result checker: every output transfer against the oldest owed readout
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (readout_q.size() == 0)
            begin
                $error("unexpected result transfer: angle %0d status %0d diag %0d crc %0d",
                       angle_raw, magnet_status, diag_flag, crc_good);
                fail_count++;
            end
            else
            begin
                want = readout_q.pop_front();
                if (angle_raw !== want.angle_raw)
                begin
                    $error("angle_raw: expected %0d, actual %0d",
                           want.angle_raw, angle_raw);
                    fail_count++;
                end
                if (magnet_status !== want.magnet_status)
                begin
                    $error("magnet_status: expected %0d, actual %0d",
                           want.magnet_status, magnet_status);
                    fail_count++;
                end
                if (diag_flag !== want.diag_flag)
                begin
                    $error("diag_flag: expected %0d, actual %0d", want.diag_flag, diag_flag);
                    fail_count++;
                end
                if (crc_good !== want.crc_good)
                begin
                    $error("crc_good: expected %0d, actual %0d", want.crc_good, crc_good);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Watchdog
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
            @(posedge clk);
        $display("angle_sensor_frame_receiver_core_tb failed");
        $finish;
    end

    // Main sequence
    initial
    begin
        logic v;
        int   goal;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table, starting with diag_enable at its reset value
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (DIRECTED[i].kind == ROW_CFG)
                set_diag_enable(DIRECTED[i].rx[0]);
            else
                send_byte(DIRECTED[i].rx, DIRECTED[i].st, DIRECTED[i].dl,
                          DIRECTED[i].typed, DIRECTED[i].res);
        end

        // Random phases: both register values first, then random ones.
        // Phase 2 runs with no idling at all; phase 5 holds the receiver off
        // while the sender streams back to back, so the DUT backs up.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == 0)
                v = 1'b0;
            else if (ph == 1)
                v = 1'b1;
            else
                v = 1'($urandom_range(0, 1));
            set_diag_enable(v);
            tx_idling = (ph != 2 && ph != 5);
            rx_idling = (ph != 2);
            if (ph == 5)
                hold_req = 1'b1;
            goal = bytes_taken + ITEMS_PER_PHASE;
            while (bytes_taken < goal)
                send_frame();
        end

        drain(12);
        if (fail_count == 0)
            $display("angle_sensor_frame_receiver_core_tb passed");
        else
            $display("angle_sensor_frame_receiver_core_tb failed");
        $finish;
    end

endmodule
